// ----- hw/rtl/bba_pkg.sv -----
package bba_pkg;

  // Pool geometry (fixed by the field widths)
  localparam int unsigned POOL_BYTES      = 1048576;
  localparam int unsigned MIN_BLOCK_BYTES = 32;
  localparam int unsigned TREE_NODE_COUNT = 65535;

  localparam int unsigned SIZE_W = 21;
  localparam int unsigned OFF_W  = 20;
  // span and base hold values up to POOL_BYTES itself
  localparam int unsigned SPAN_W = $clog2(POOL_BYTES) + 1;
  // rounded request reaches at most POOL_BYTES; one spare bit is kept
  localparam int unsigned WANT_W = SPAN_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    NODE_FREE  = 2'd0,
    NODE_USED  = 2'd1,
    NODE_SPLIT = 2'd2
  } node_state_e;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  release_offset;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [OFF_W-1:0] block_offset;
  } rsp_t;

endpackage

// ----- hw/rtl/bba_req_if.sv -----
interface bba_req_if;
  import bba_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  release_offset;

  modport source (output valid, output operation, output request_size,
                  output release_offset, input ready);
  modport sink   (input valid, input operation, input request_size,
                  input release_offset, output ready);
endinterface

// ----- hw/rtl/bba_rsp_if.sv -----
interface bba_rsp_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic [OFF_W-1:0] block_offset;

  modport source (output valid, output status, output block_offset, input ready);
  modport sink   (input valid, input status, input block_offset, output ready);
endinterface

// ----- hw/rtl/bba_node_mem.sv -----
module bba_node_mem #(
  parameter int unsigned NODE_COUNT = bba_pkg::TREE_NODE_COUNT,
  parameter int unsigned IDX_W      = $clog2(NODE_COUNT + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output bba_pkg::node_state_e rd_data_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  bba_pkg::node_state_e wr_data_i,
  output logic                 clearing_o
);
  import bba_pkg::*;

  node_state_e mem [NODE_COUNT];
  node_state_e rd_data_q;
  logic [IDX_W-1:0] clr_addr_q;
  logic clearing_q;

  // sweep every node back to free after reset, one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      if (clr_addr_q == IDX_W'(NODE_COUNT - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= NODE_FREE;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;
endmodule

// ----- hw/rtl/bba_walker.sv -----
module bba_walker #(
  parameter int unsigned NODE_COUNT = bba_pkg::TREE_NODE_COUNT,
  parameter int unsigned IDX_W      = $clog2(NODE_COUNT + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  bba_pkg::req_t        req_i,
  output logic                 ready_o,
  input  logic                 clearing_i,
  output logic                 rd_en_o,
  output logic [IDX_W-1:0]     rd_addr_o,
  input  bba_pkg::node_state_e rd_data_i,
  output logic                 wr_en_o,
  output logic [IDX_W-1:0]     wr_addr_o,
  output bba_pkg::node_state_e wr_data_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output bba_pkg::rsp_t        res_o
);
  import bba_pkg::*;

  localparam int unsigned IW1 = IDX_W + 1;

  typedef enum logic [3:0] {
    W_IDLE, W_ROUND, A_RD, A_EV, A_BACK, F_RD, F_EV, U_STEP, U_EV, W_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [IW1-1:0]    idx_q, idx_d;
  logic [SPAN_W-1:0] span_q, span_d, base_q, base_d, target_q, target_d;
  logic [WANT_W-1:0] want_q, want_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic              status_q, status_d;
  logic [OFF_W-1:0]  offset_q, offset_d;
  logic              cfree_q, cfree_d;

  logic [IW1-1:0]    parent, rchild, sibling;
  logic [SPAN_W-1:0] half;
  logic              in_tree;

  always_comb begin
    parent  = (idx_q - 1'b1) >> 1;
    rchild  = (parent << 1) + IW1'(2);
    sibling = idx_q[0] ? idx_q + 1'b1 : idx_q - 1'b1;
    half    = span_q >> 1;
    in_tree = idx_q < IW1'(NODE_COUNT);
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    span_d   = span_q;
    base_d   = base_q;
    target_d = target_q;
    want_d   = want_q;
    size_d   = size_q;
    status_d = status_q;
    offset_d = offset_q;
    cfree_d  = cfree_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q[IDX_W-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q[IDX_W-1:0];
    wr_data_o = NODE_FREE;

    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          status_d = STATUS_DONE;
          offset_d = '0;
          idx_d    = '0;
          span_d   = SPAN_W'(POOL_BYTES);
          base_d   = '0;
          size_d   = req_i.request_size;
          target_d = SPAN_W'(req_i.release_offset);
          want_d   = WANT_W'(MIN_BLOCK_BYTES);
          if (req_i.operation == OP_ALLOC) begin
            if (req_i.request_size == '0 ||
                SPAN_W'(req_i.request_size) > SPAN_W'(POOL_BYTES)) begin
              status_d = STATUS_FAIL;
              state_d  = W_DONE;
            end else begin
              state_d = W_ROUND;
            end
          end else if (SPAN_W'(req_i.release_offset) >= SPAN_W'(POOL_BYTES)) begin
            state_d = W_DONE;
          end else begin
            state_d = F_RD;
          end
        end
      end
      W_ROUND: begin
        if (want_q < WANT_W'(size_q)) begin
          want_d = want_q << 1;
        end else begin
          state_d = A_RD;
        end
      end
      A_RD: begin
        if (!in_tree || WANT_W'(span_q) < want_q) begin
          state_d = A_BACK;
        end else begin
          rd_en_o = 1'b1;
          state_d = A_EV;
        end
      end
      A_EV: begin
        case (rd_data_i)
          NODE_USED: state_d = A_BACK;
          NODE_FREE: begin
            if (WANT_W'(span_q) == want_q) begin
              wr_en_o   = 1'b1;
              wr_data_o = NODE_USED;
              offset_d  = base_q[OFF_W-1:0];
              state_d   = W_DONE;
            end else if (span_q <= SPAN_W'(MIN_BLOCK_BYTES)) begin
              state_d = A_BACK;
            end else begin
              wr_en_o   = 1'b1;
              wr_data_o = NODE_SPLIT;
              idx_d     = (idx_q << 1) + 1'b1;
              span_d    = half;
              state_d   = A_RD;
            end
          end
          default: begin
            idx_d   = (idx_q << 1) + 1'b1;
            span_d  = half;
            state_d = A_RD;
          end
        endcase
      end
      A_BACK: begin
        // climb past exhausted right children, then try the next sibling
        if (idx_q == '0) begin
          status_d = STATUS_FAIL;
          state_d  = W_DONE;
        end else if (idx_q[0]) begin
          idx_d   = idx_q + 1'b1;
          base_d  = base_q + span_q;
          state_d = A_RD;
        end else begin
          idx_d  = parent;
          base_d = base_q - span_q;
          span_d = span_q << 1;
        end
      end
      F_RD: begin
        if (!in_tree) begin
          cfree_d = 1'b0;
          state_d = U_STEP;
        end else begin
          rd_en_o = 1'b1;
          state_d = F_EV;
        end
      end
      F_EV: begin
        case (rd_data_i)
          NODE_FREE: begin
            cfree_d = 1'b1;
            state_d = U_STEP;
          end
          NODE_USED: begin
            if (base_q == target_q) begin
              wr_en_o   = 1'b1;
              wr_data_o = NODE_FREE;
              cfree_d   = 1'b1;
            end else begin
              cfree_d = 1'b0;
            end
            state_d = U_STEP;
          end
          default: begin
            span_d  = half;
            state_d = F_RD;
            if (target_q < base_q + half) begin
              idx_d = (idx_q << 1) + 1'b1;
            end else begin
              idx_d  = (idx_q << 1) + IW1'(2);
              base_d = base_q + half;
            end
          end
        endcase
      end
      U_STEP: begin
        if (idx_q == '0) begin
          state_d = W_DONE;
        end else if (rchild >= IW1'(NODE_COUNT)) begin
          cfree_d = 1'b0;
          idx_d   = parent;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = sibling[IDX_W-1:0];
          state_d   = U_EV;
        end
      end
      U_EV: begin
        // the sibling is never written during this walk, so its read is current
        if (cfree_q && rd_data_i == NODE_FREE) begin
          wr_en_o   = 1'b1;
          wr_addr_o = parent[IDX_W-1:0];
          wr_data_o = NODE_FREE;
          cfree_d   = 1'b1;
        end else begin
          cfree_d = 1'b0;
        end
        idx_d   = parent;
        state_d = U_STEP;
      end
      W_DONE: begin
        if (res_ready_i) begin
          state_d = W_IDLE;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    span_q   <= span_d;
    base_q   <= base_d;
    target_q <= target_d;
    want_q   <= want_d;
    size_q   <= size_d;
    status_q <= status_d;
    offset_q <= offset_d;
    cfree_q  <= cfree_d;
  end

  assign ready_o      = (state_q == W_IDLE) && !clearing_i;
  assign res_valid_o  = (state_q == W_DONE);
  assign res_o.status       = status_q;
  assign res_o.block_offset = offset_q;
endmodule

// ----- hw/rtl/buddy_block_allocator.sv -----
// Binary buddy allocator over a pool given as byte offsets.
// Request channel req_i carries operation, request_size and release_offset;
// a transfer takes place on a clock edge with valid and ready both high.
// Response channel rsp_o returns one item per request: status and
// block_offset (offset of the allocated block, 0 on failure and on free).
// Node states live in one synchronous memory of TREE_NODE_COUNT entries.
// An allocate first rounds the request up by doubling the minimum block,
// then runs a depth first search that reads each node it visits and
// backtracks past used or too small subtrees; a free walks down to the
// block, then back up, merging each level whose sibling is also free.
// One request is in progress at a time; a finished response sits in the
// output register, so the next request is taken while it waits.
// Reset: the memory is swept to free, one node per cycle;
// req_i.ready stays low until the sweep ends.
// A stalled receiver holds the response in the output register; a walker that
// finishes another request then waits in its done state until that one is taken.
module buddy_block_allocator #(
  parameter int unsigned TREE_NODE_COUNT = bba_pkg::TREE_NODE_COUNT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bba_req_if.sink      req_i,
  bba_rsp_if.source    rsp_o
);
  import bba_pkg::*;

  localparam int unsigned IDX_W = $clog2(TREE_NODE_COUNT + 1);

  req_t             req;
  rsp_t             res;
  logic             start, walk_ready, clearing;
  logic             res_valid, res_load;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  node_state_e      rd_data, wr_data;
  logic             out_valid_q;
  rsp_t             out_q;

  assign req.operation      = req_i.operation;
  assign req.request_size   = req_i.request_size;
  assign req.release_offset = req_i.release_offset;
  assign req_i.ready        = walk_ready;
  assign start              = req_i.valid && walk_ready;

  bba_node_mem #(
    .NODE_COUNT (TREE_NODE_COUNT),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .clearing_o (clearing)
  );

  bba_walker #(
    .NODE_COUNT (TREE_NODE_COUNT),
    .IDX_W      (IDX_W)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .ready_o     (walk_ready),
    .clearing_i  (clearing),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_load),
    .res_o       (res)
  );

  // load the output register when it is empty or being drained
  assign res_load = res_valid && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.block_offset = out_q.block_offset;

  // no request is taken during the clearing sweep
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !req_i.ready)
    else $error("request accepted during clearing sweep");

  // one request at a time: the walker is busy straight after a transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second request accepted while walking");

  // a response is only loaded while the walker holds no new request
  a_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !req_i.ready && !rd_en && !wr_en)
    else $error("response loaded while walker active");
endmodule
